// ===== rtl/tra_pkg.sv =====
// ----------------------------------------------------------------------------
// tra_pkg
// shared types and constants for the temp region allocator
// ----------------------------------------------------------------------------
package tra_pkg;

  localparam int unsigned OFF_W    = 20;
  localparam int unsigned SIZE_W   = 20;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LIVE_W   = 7;

  // region size and default table depth
  localparam logic [21:0] REGION_BYTES   = 22'hFC000;
  localparam int unsigned MAX_BLOCKS_DEF = 64;

  // allocation granule minus one
  localparam logic [20:0] ALIGN_MASK = 21'h7;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NO_SPACE   = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_OUTSIDE    = 3'd3,
    ST_NOT_FOUND  = 3'd4
  } status_t;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FLUSH,
    S_FINAL,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic decode;
    logic scan_rd;
    logic commit;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_free;
    logic outside;
    logic empty;
    logic last_rd;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/tra_req_if.sv =====
// ----------------------------------------------------------------------------
// tra_req_if
// request channel: allocate or free word with valid/ready handshake
// ----------------------------------------------------------------------------
interface tra_req_if;
  import tra_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [SIZE_W-1:0] alloc_size;
  logic [OFF_W-1:0]  free_offset;

  modport source (output valid, action, alloc_size, free_offset, input ready);
  modport sink   (input valid, action, alloc_size, free_offset, output ready);
endinterface

// ===== rtl/tra_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tra_rsp_if
// result channel: one word per request with valid/ready handshake
// ----------------------------------------------------------------------------
interface tra_rsp_if;
  import tra_pkg::*;

  logic                valid;
  logic                ready;
  logic [OFF_W-1:0]    block_offset;
  logic [STATUS_W-1:0] status;
  logic [OFF_W-1:0]    used_bytes;
  logic [LIVE_W-1:0]   live_blocks;
  logic                all_free;

  modport source (output valid, block_offset, status, used_bytes, live_blocks, all_free,
                  input ready);
  modport sink   (input valid, block_offset, status, used_bytes, live_blocks, all_free,
                  output ready);
endinterface

// ===== rtl/temp_region_allocator_top.sv =====
// ----------------------------------------------------------------------------
// temp_region_allocator_top
// stack-style allocator over a fixed region with out-of-order free
//
// Hands out blocks downward from the top of a 0xFC000-byte region; sizes are
// rounded up to 8 bytes and each live block leaves its top mark in an on-chip
// table of MAX_BLOCKS entries. One request word is taken at a time and gives
// exactly one result word. An allocate, a free outside the region or a free
// while the table is empty goes from decode straight to the result hand-off.
// Any other free scans the mark table once through its single read port, one
// entry per cycle, moving survivors down and tracking the highest remaining
// mark. A new request can be taken once the previous result is loaded into
// the output register, even while that result still waits for the sink. No
// clearing pass follows reset; table entries beyond the live count are never
// read.
// ----------------------------------------------------------------------------
module temp_region_allocator_top #(
  parameter int unsigned MAX_BLOCKS = tra_pkg::MAX_BLOCKS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tra_req_if.sink    req,
  tra_rsp_if.source  rsp
);
  import tra_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  // request handshake is owned by the controller
  assign req.ready = in_ready;

  tra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // state, mark table and result register
  tra_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .in_action        (req.action),
    .in_alloc_size    (req.alloc_size),
    .in_free_offset   (req.free_offset),
    .out_valid        (rsp.valid),
    .out_ready        (rsp.ready),
    .out_block_offset (rsp.block_offset),
    .out_status       (rsp.status),
    .out_used_bytes   (rsp.used_bytes),
    .out_live_blocks  (rsp.live_blocks),
    .out_all_free     (rsp.all_free)
  );

endmodule

// ===== rtl/tra_ctrl.sv =====
// ----------------------------------------------------------------------------
// tra_ctrl
// sequencing of decode, table scan, commit and result hand-off
// ----------------------------------------------------------------------------
module tra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tra_pkg::dp_stat_t   stat,
  output tra_pkg::ctrl_cmd_t  cmd
);
  import tra_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.is_free && !stat.outside && !stat.empty) state_next = S_SCAN;
        else                                             state_next = S_EMIT;
      end
      S_SCAN: begin
        if (stat.last_rd) state_next = S_FLUSH;
      end
      S_FLUSH: state_next = S_FINAL;
      S_FINAL: state_next = S_EMIT;
      S_EMIT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE: cmd.decode  = 1'b1;
      S_SCAN:   cmd.scan_rd = 1'b1;
      S_FLUSH:  ;
      S_FINAL:  cmd.commit  = 1'b1;
      S_EMIT:   cmd.emit    = stat.out_free;
      default:  ;
    endcase
  end

endmodule

// ===== rtl/tra_dp.sv =====
// ----------------------------------------------------------------------------
// tra_dp
// allocator state, mark table memory, compacting scan and result register
// ----------------------------------------------------------------------------
module tra_dp #(
  parameter int unsigned MAX_BLOCKS = tra_pkg::MAX_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tra_pkg::ctrl_cmd_t            cmd,
  output tra_pkg::dp_stat_t             stat,
  input  logic                          in_action,
  input  logic [tra_pkg::SIZE_W-1:0]    in_alloc_size,
  input  logic [tra_pkg::OFF_W-1:0]     in_free_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tra_pkg::OFF_W-1:0]     out_block_offset,
  output logic [tra_pkg::STATUS_W-1:0]  out_status,
  output logic [tra_pkg::OFF_W-1:0]     out_used_bytes,
  output logic [tra_pkg::LIVE_W-1:0]    out_live_blocks,
  output logic                          out_all_free
);
  import tra_pkg::*;

  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned EW = $clog2(MAX_BLOCKS + 1);
  localparam logic [EW-1:0] MAX_CNT = EW'(MAX_BLOCKS);

  // latched request
  logic              act;
  logic [SIZE_W-1:0] size;
  logic [OFF_W-1:0]  off;

  // allocator state
  logic [OFF_W-1:0] used_count;
  logic [EW-1:0]    entry_count;
  logic [OFF_W-1:0] mark_table [MAX_BLOCKS];

  // per-item result
  logic [OFF_W-1:0] boff;
  status_t          status;

  // scan
  logic [OFF_W-1:0] mark;
  logic [EW-1:0]    rd_idx;
  logic [EW-1:0]    kept;
  logic [OFF_W-1:0] top;
  logic             hit;
  logic             proc_vld;
  logic [OFF_W-1:0] mem_q;

  // output register
  logic [OFF_W-1:0]    q_boff;
  logic [STATUS_W-1:0] q_status;
  logic [OFF_W-1:0]    q_used;
  logic [LIVE_W-1:0]   q_live;
  logic                q_all_free;

  logic [20:0]      rounded;
  logic [21:0]      total;
  logic             no_space;
  logic             full;
  logic             outside;
  logic             match;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [OFF_W-1:0] mem_wdata;
  logic [EW+LIVE_W-1:0] live_ext;

  assign rounded  = ({1'b0, size} + ALIGN_MASK) & ~ALIGN_MASK;
  assign total    = {2'b00, used_count} + {1'b0, rounded};
  assign no_space = total >= REGION_BYTES;
  assign full     = entry_count >= MAX_CNT;
  assign outside  = {2'b00, off} > REGION_BYTES;
  assign match    = mem_q == mark;
  assign live_ext = {{LIVE_W{1'b0}}, entry_count};

  assign stat.is_free  = act == ACT_FREE;
  assign stat.outside  = outside;
  assign stat.empty    = entry_count == '0;
  assign stat.last_rd  = ({1'b0, rd_idx} + 1'b1) == {1'b0, entry_count};
  assign stat.out_free = !out_valid || out_ready;

  // single write port: alloc append or compaction move, never both
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = entry_count[AW-1:0];
    mem_wdata = total[OFF_W-1:0];
    if (cmd.decode && act == ACT_ALLOC && !no_space && !full) begin
      mem_we = 1'b1;
    end else if (proc_vld && !match) begin
      mem_we    = 1'b1;
      mem_waddr = kept[AW-1:0];
      mem_wdata = mem_q;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mark_table[mem_waddr] <= mem_wdata;
    if (cmd.scan_rd) mem_q <= mark_table[rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= in_action;
      size <= in_alloc_size;
      off  <= in_free_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count  <= '0;
      entry_count <= '0;
      proc_vld    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      proc_vld <= cmd.scan_rd;
      if (cmd.decode && act == ACT_ALLOC && !no_space && !full) begin
        used_count  <= total[OFF_W-1:0];
        entry_count <= entry_count + 1'b1;
      end
      if (cmd.commit && hit) begin
        used_count  <= top;
        entry_count <= kept;
      end
      if (cmd.emit)      out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // decode, scan bookkeeping and commit status
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      boff   <= (act == ACT_ALLOC && !no_space && !full) ?
                (REGION_BYTES[OFF_W-1:0] - total[OFF_W-1:0]) : '0;
      rd_idx <= '0;
      kept   <= '0;
      top    <= '0;
      hit    <= 1'b0;
      mark   <= REGION_BYTES[OFF_W-1:0] - off;
      if (act == ACT_ALLOC) begin
        if (no_space) begin
          status <= ST_NO_SPACE;
        end else if (full) begin
          status <= ST_TABLE_FULL;
        end else begin
          status <= ST_OK;
        end
      end else if (outside) begin
        status <= ST_OUTSIDE;
      end else begin
        status <= ST_NOT_FOUND;
      end
    end
    if (cmd.scan_rd) rd_idx <= rd_idx + 1'b1;
    if (proc_vld) begin
      if (match) begin
        hit <= 1'b1;
      end else begin
        kept <= kept + 1'b1;
        if (mem_q > top) top <= mem_q;
      end
    end
    if (cmd.commit) begin
      status <= hit ? ST_OK : ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      q_boff     <= boff;
      q_status   <= status;
      q_used     <= used_count;
      q_live     <= live_ext[LIVE_W-1:0];
      q_all_free <= used_count == '0;
    end
  end

  assign out_block_offset = q_boff;
  assign out_status       = q_status;
  assign out_used_bytes   = q_used;
  assign out_live_blocks  = q_live;
  assign out_all_free     = q_all_free;

endmodule
